// ----- hw/rtl/nbtc_pkg.sv -----
// ----------------------------------------------------------------------------
// nbtc_pkg
// Shared types, constants and codes for the naive Bayes text classifier.
// ----------------------------------------------------------------------------
package nbtc_pkg;

    localparam int VOCAB_DEPTH_DEF       = 131072;
    localparam int COUNT_BITS_DEF        = 24;
    localparam int LOG_FRACTION_BITS_DEF = 16;

    localparam int OP_BITS    = 2;
    localparam int WORD_BITS  = 17;
    localparam int CNT_BITS   = 16;
    localparam int RATE_BITS  = 4;
    localparam int VOC_BITS   = 18;
    localparam int TOTAL_BITS = 32;
    localparam int SCORE_BITS = 48;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [OP_BITS-1:0] OP_TRAIN = 2'd0;
    localparam logic [OP_BITS-1:0] OP_MARK  = 2'd1;
    localparam logic [OP_BITS-1:0] OP_TEST  = 2'd2;
    localparam logic [OP_BITS-1:0] OP_END   = 2'd3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_VOCAB  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SVOCAB = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_THRESH = 2'd2;

    localparam logic [VOC_BITS-1:0]  VOCAB_RST  = 18'd89527;
    localparam logic [VOC_BITS-1:0]  SVOCAB_RST = 18'd89354;
    localparam logic [RATE_BITS-1:0] THRESH_RST = 4'd5;

    typedef struct packed {
        logic [OP_BITS-1:0]   op;
        logic [WORD_BITS-1:0] word;
        logic [CNT_BITS-1:0]  cnt;
        logic                 positive;
    } cmd_t;

endpackage

// ----- hw/rtl/nbtc_front.sv -----
// ----------------------------------------------------------------------------
// nbtc_front
// Input side: takes beats, decodes the class and pushes commands to a queue.
// ----------------------------------------------------------------------------
module nbtc_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [nbtc_pkg::OP_BITS-1:0]   s_operation,
    input  logic [nbtc_pkg::WORD_BITS-1:0] s_word_index,
    input  logic [nbtc_pkg::CNT_BITS-1:0]  s_word_count,
    input  logic [nbtc_pkg::RATE_BITS-1:0] s_rating,
    input  logic [nbtc_pkg::RATE_BITS-1:0] thresh,
    output logic                           q_valid,
    input  logic                           q_ready,
    output nbtc_pkg::cmd_t                 q_cmd
);
    localparam int QD = 2;
    nbtc_pkg::cmd_t q_mem [QD];
    logic [0:0] wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic push, pop;

    assign s_ready = (cnt_reg != 2'(QD));
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop     = q_valid && q_ready;
    assign q_cmd   = q_mem[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wp_reg] <= '{op: s_operation, word: s_word_index, cnt: s_word_count,
                               positive: (s_rating > thresh)};
        end
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

// ----- hw/rtl/nbtc_log2.sv -----
// ----------------------------------------------------------------------------
// nbtc_log2
// Iterative fixed-point log2: one squaring step per cycle.
// ----------------------------------------------------------------------------
module nbtc_log2 #(
    parameter int FB = nbtc_pkg::LOG_FRACTION_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [32:0] x,
    output logic        done,
    output logic [FB+5:0] result
);
    logic [32:0] m_reg;
    logic [5:0]  n_reg;
    logic [FB-1:0] f_reg;
    logic [$clog2(FB+1)-1:0] i_reg;
    logic busy_reg, zero_reg;
    logic [5:0] n_c;
    logic [63:0] sq;
    logic [65:0] sq2;

    always_comb begin
        n_c = '0;
        for (int b = 0; b < 33; b++) if (x[b]) n_c = 6'(b);
    end
    assign sq2 = 66'(m_reg) * 66'(m_reg);
    assign sq  = 64'(sq2 >> 31);
    assign done = !busy_reg;
    assign result = zero_reg ? '0 : {n_reg, f_reg};

    always_ff @(posedge aclk) begin
        if (start) begin
            m_reg <= (n_c >= 6'd31) ? 33'(x >> (n_c - 6'd31)) : 33'(x << (6'd31 - n_c));
            n_reg <= n_c;
            zero_reg <= (x == '0);
            f_reg <= '0;
            i_reg <= '0;
        end else if (busy_reg) begin
            m_reg <= sq[32] ? 33'(sq >> 1) : 33'(sq);
            f_reg <= {f_reg[FB-2:0], sq[32]};
            i_reg <= i_reg + 1'b1;
        end
        if (!aresetn) busy_reg <= 1'b0;
        else if (start) busy_reg <= 1'b1;
        else if (busy_reg && i_reg == ($clog2(FB+1))'(FB-1)) busy_reg <= 1'b0;
    end
endmodule

// ----- hw/rtl/nbtc_back.sv -----
// ----------------------------------------------------------------------------
// nbtc_back
// Execution side: table updates, stopword marks, scoring and decisions.
// ----------------------------------------------------------------------------
module nbtc_back #(
    parameter int VOCAB_DEPTH       = nbtc_pkg::VOCAB_DEPTH_DEF,
    parameter int COUNT_BITS        = nbtc_pkg::COUNT_BITS_DEF,
    parameter int LOG_FRACTION_BITS = nbtc_pkg::LOG_FRACTION_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  nbtc_pkg::cmd_t                q_cmd,
    input  logic [nbtc_pkg::VOC_BITS-1:0] vocab,
    input  logic [nbtc_pkg::VOC_BITS-1:0] svocab,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_pred_multinomial,
    output logic                          m_pred_binary,
    output logic                          m_pred_multinomial_filtered,
    output logic                          m_pred_binary_filtered,
    output logic                          m_actual_positive
);
    localparam int AW = $clog2(VOCAB_DEPTH);
    localparam int FB = LOG_FRACTION_BITS;
    localparam int SB = nbtc_pkg::SCORE_BITS;
    localparam int TB = nbtc_pkg::TOTAL_BITS;
    localparam int RW = 4 * COUNT_BITS + 1;
    localparam int SW = ((COUNT_BITS > nbtc_pkg::CNT_BITS) ? COUNT_BITS
                                                           : nbtc_pkg::CNT_BITS) + 1;
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    localparam logic [3:0] ST_CLR = 4'd0, ST_IDLE = 4'd1, ST_RD = 4'd2, ST_WAIT = 4'd3,
        ST_EXEC = 4'd4, ST_LA = 4'd5, ST_LB = 4'd6, ST_MUL = 4'd7, ST_ACC = 4'd8,
        ST_OUT = 4'd9;

    logic [RW-1:0] mem [VOCAB_DEPTH];
    logic [RW-1:0] rd_reg;
    logic [AW:0]   clr_reg;
    logic [3:0]    st_reg;
    nbtc_pkg::cmd_t c_reg;
    logic ok_reg;
    logic [TB-1:0] tot_reg [8];
    logic signed [SB-1:0] sc_reg [8];
    logic [2:0] k_reg;
    logic [FB+5:0] la_reg;
    logic signed [FB+6:0] w_reg;
    logic signed [FB+24:0] p_reg;
    logic wr_en;
    logic [RW-1:0] wr_data;
    logic [AW-1:0] addr;
    logic [COUNT_BITS-1:0] pw, nw, pd, nd, cv;
    logic mk;
    logic lg_start, lg_done;
    logic [32:0] lg_x;
    logic [FB+5:0] lg_res;
    logic [SW-1:0] sw;
    logic [COUNT_BITS:0] sd;
    logic [COUNT_BITS-1:0] nwc, ndc, dw, dd;
    logic signed [SB:0] s_sum;
    logic out_v_reg;
    logic [4:0] out_reg;

    assign {mk, nd, pd, nw, pw} = rd_reg;
    assign addr = AW'(c_reg.word);
    assign q_ready = (st_reg == ST_IDLE) && !out_v_reg;
    assign m_valid = out_v_reg;
    assign {m_actual_positive, m_pred_binary_filtered, m_pred_multinomial_filtered,
            m_pred_binary, m_pred_multinomial} = out_reg;

    nbtc_log2 #(.FB(FB)) u_log (
        .aclk, .aresetn, .start(lg_start), .x(lg_x), .done(lg_done), .result(lg_res)
    );

    always_comb begin
        unique case (k_reg[1:0])
            2'd0: cv = pw;
            2'd1: cv = nw;
            2'd2: cv = pd;
            default: cv = nd;
        endcase
        if (!ok_reg || (k_reg[2] && mk)) cv = '0;
    end

    assign lg_start = (st_reg == ST_EXEC && c_reg.op == nbtc_pkg::OP_TEST) ||
                      (st_reg == ST_LA && lg_done);
    assign lg_x = (st_reg == ST_EXEC) ? 33'(cv) + 33'd1
                : 33'(tot_reg[k_reg]) + 33'(k_reg[2] ? svocab : vocab);

    assign sw  = SW'(c_reg.positive ? pw : nw) + SW'(c_reg.cnt);
    assign sd  = (COUNT_BITS+1)'(c_reg.positive ? pd : nd) + (COUNT_BITS+1)'(1);
    assign nwc = (sw > SW'(CMAX)) ? CMAX : sw[COUNT_BITS-1:0];
    assign ndc = sd[COUNT_BITS] ? CMAX : sd[COUNT_BITS-1:0];
    assign dw  = nwc - (c_reg.positive ? pw : nw);
    assign dd  = ndc - (c_reg.positive ? pd : nd);

    always_comb begin
        wr_en = 1'b0;
        wr_data = rd_reg;
        if (st_reg == ST_CLR) begin
            wr_en = 1'b1;
            wr_data = '0;
        end else if (st_reg == ST_EXEC && ok_reg) begin
            if (c_reg.op == nbtc_pkg::OP_TRAIN) begin
                wr_en = 1'b1;
                wr_data = c_reg.positive ? {mk, nd, ndc, nw, nwc} : {mk, ndc, pd, nwc, pw};
            end else if (c_reg.op == nbtc_pkg::OP_MARK && !mk) begin
                wr_en = 1'b1;
                wr_data = {1'b1, nd, pd, nw, pw};
            end
        end
    end

    assign s_sum = (SB+1)'(sc_reg[k_reg]) + (SB+1)'(p_reg);

    always_ff @(posedge aclk) begin
        if (wr_en) mem[(st_reg == ST_CLR) ? clr_reg[AW-1:0] : addr] <= wr_data;
        if (st_reg == ST_RD) rd_reg <= mem[addr];
    end

    function automatic logic [TB-1:0] tadd(input logic [TB-1:0] t, input logic [COUNT_BITS-1:0] d);
        logic [TB:0] s;
        s = (TB+1)'(t) + (TB+1)'(d);
        return s[TB] ? '1 : s[TB-1:0];
    endfunction

    function automatic logic [TB-1:0] tsub(input logic [TB-1:0] t, input logic [COUNT_BITS-1:0] d);
        return (t > TB'(d)) ? t - TB'(d) : '0;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_CLR;
            clr_reg <= '0;
            out_v_reg <= 1'b0;
            for (int j = 0; j < 8; j++) begin
                tot_reg[j] <= '0;
                sc_reg[j] <= '0;
            end
        end else begin
            if (out_v_reg && m_ready) out_v_reg <= 1'b0;
            unique case (st_reg)
                ST_CLR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (AW+1)'(VOCAB_DEPTH - 1)) st_reg <= ST_IDLE;
                end
                ST_IDLE: if (q_valid && !out_v_reg) begin
                    c_reg <= q_cmd;
                    ok_reg <= (32'(q_cmd.word) < 32'(VOCAB_DEPTH));
                    k_reg <= '0;
                    st_reg <= (q_cmd.op == nbtc_pkg::OP_END) ? ST_OUT : ST_RD;
                end
                ST_RD: st_reg <= ST_WAIT;
                ST_WAIT: st_reg <= ST_EXEC;
                ST_EXEC: begin
                    if (c_reg.op == nbtc_pkg::OP_TEST) st_reg <= ST_LA;
                    else begin
                        st_reg <= ST_IDLE;
                        if (ok_reg && c_reg.op == nbtc_pkg::OP_TRAIN) begin
                            if (c_reg.positive) begin
                                tot_reg[0] <= tadd(tot_reg[0], dw);
                                tot_reg[2] <= tadd(tot_reg[2], dd);
                                if (!mk) begin
                                    tot_reg[4] <= tadd(tot_reg[4], dw);
                                    tot_reg[6] <= tadd(tot_reg[6], dd);
                                end
                            end else begin
                                tot_reg[1] <= tadd(tot_reg[1], dw);
                                tot_reg[3] <= tadd(tot_reg[3], dd);
                                if (!mk) begin
                                    tot_reg[5] <= tadd(tot_reg[5], dw);
                                    tot_reg[7] <= tadd(tot_reg[7], dd);
                                end
                            end
                        end else if (ok_reg && c_reg.op == nbtc_pkg::OP_MARK && !mk) begin
                            tot_reg[4] <= tsub(tot_reg[4], pw);
                            tot_reg[5] <= tsub(tot_reg[5], nw);
                            tot_reg[6] <= tsub(tot_reg[6], pd);
                            tot_reg[7] <= tsub(tot_reg[7], nd);
                        end
                    end
                end
                ST_LA: if (lg_done) begin
                    la_reg <= lg_res;
                    st_reg <= ST_LB;
                end
                ST_LB: if (lg_done) begin
                    w_reg <= $signed({1'b0, la_reg}) - $signed({1'b0, lg_res});
                    st_reg <= ST_MUL;
                end
                ST_MUL: begin
                    p_reg <= (k_reg[1] == 1'b0)
                        ? w_reg * $signed({1'b0, c_reg.cnt}) : (FB+25)'(w_reg);
                    st_reg <= ST_ACC;
                end
                ST_ACC: begin
                    if (s_sum[SB] != s_sum[SB-1])
                        sc_reg[k_reg] <= s_sum[SB] ? {1'b1, {(SB-1){1'b0}}}
                                                   : {1'b0, {(SB-1){1'b1}}};
                    else sc_reg[k_reg] <= s_sum[SB-1:0];
                    k_reg <= k_reg + 1'b1;
                    st_reg <= (k_reg == 3'd7) ? ST_IDLE : ST_EXEC;
                end
                ST_OUT: begin
                    out_reg <= {c_reg.positive, sc_reg[6] > sc_reg[7], sc_reg[4] > sc_reg[5],
                                sc_reg[2] > sc_reg[3], sc_reg[0] > sc_reg[1]};
                    out_v_reg <= 1'b1;
                    for (int j = 0; j < 8; j++) sc_reg[j] <= '0;
                    st_reg <= ST_IDLE;
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

// ----- hw/rtl/naive_bayes_text_classifier_top.sv -----
// ----------------------------------------------------------------------------
// naive_bayes_text_classifier_top
// Four-variant multinomial naive Bayes text classifier.
// ----------------------------------------------------------------------------
// Train and mark beats go through a table read and a write back in the back
// end. A test token is scored with the one shared bit-serial log2 unit, which
// runs twice per class score; the eight class scores are worked in turn. An
// end-of-document beat goes straight to the output stage. A two-beat queue
// sits in front. After reset, a clearing pass over every entry of the word
// table runs before beats leave the input queue; config writes are taken
// meanwhile.
module naive_bayes_text_classifier_top #(
    parameter int VOCAB_DEPTH       = nbtc_pkg::VOCAB_DEPTH_DEF,
    parameter int COUNT_BITS        = nbtc_pkg::COUNT_BITS_DEF,
    parameter int LOG_FRACTION_BITS = nbtc_pkg::LOG_FRACTION_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [nbtc_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [nbtc_pkg::VOC_BITS-1:0]     cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [nbtc_pkg::OP_BITS-1:0]      s_operation,
    input  logic [nbtc_pkg::WORD_BITS-1:0]    s_word_index,
    input  logic [nbtc_pkg::CNT_BITS-1:0]     s_word_count,
    input  logic [nbtc_pkg::RATE_BITS-1:0]    s_rating,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_pred_multinomial,
    output logic                              m_pred_binary,
    output logic                              m_pred_multinomial_filtered,
    output logic                              m_pred_binary_filtered,
    output logic                              m_actual_positive
);
    logic [nbtc_pkg::VOC_BITS-1:0]  vocab_reg, svocab_reg;
    logic [nbtc_pkg::RATE_BITS-1:0] thresh_reg;
    logic q_valid, q_ready;
    nbtc_pkg::cmd_t q_cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vocab_reg  <= nbtc_pkg::VOCAB_RST;
            svocab_reg <= nbtc_pkg::SVOCAB_RST;
            thresh_reg <= nbtc_pkg::THRESH_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                nbtc_pkg::CFG_VOCAB:  vocab_reg <= cfg_data;
                nbtc_pkg::CFG_SVOCAB: svocab_reg <= cfg_data;
                nbtc_pkg::CFG_THRESH: thresh_reg <= cfg_data[nbtc_pkg::RATE_BITS-1:0];
                default: ;
            endcase
        end
    end

    nbtc_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_operation, .s_word_index,
        .s_word_count, .s_rating, .thresh(thresh_reg), .q_valid, .q_ready, .q_cmd
    );

    nbtc_back #(
        .VOCAB_DEPTH(VOCAB_DEPTH), .COUNT_BITS(COUNT_BITS),
        .LOG_FRACTION_BITS(LOG_FRACTION_BITS)
    ) u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_cmd, .vocab(vocab_reg),
        .svocab(svocab_reg), .m_valid, .m_ready, .m_pred_multinomial,
        .m_pred_binary, .m_pred_multinomial_filtered, .m_pred_binary_filtered,
        .m_actual_positive
    );
endmodule

// ----- hw/rtl/nbtc_checker.sv -----
// ----------------------------------------------------------------------------
// nbtc_props
// Port-level checks on the classifier's handshakes and result channel.
// ----------------------------------------------------------------------------
module nbtc_props (
    input logic aclk,
    input logic aresetn,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_pred_multinomial,
    input logic m_pred_binary,
    input logic m_pred_multinomial_filtered,
    input logic m_pred_binary_filtered,
    input logic m_actual_positive
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable({m_pred_multinomial, m_pred_binary,
            m_pred_multinomial_filtered, m_pred_binary_filtered, m_actual_positive}))
        else $error("result beat dropped or changed while stalled");
    a_no_rst_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result after reset");
    a_known: assert property (@(posedge aclk) disable iff (!aresetn)
        !$isunknown({s_ready, m_valid}))
        else $error("handshake unknown");
    a_payload_known: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !$isunknown({m_pred_multinomial, m_pred_binary,
            m_pred_multinomial_filtered, m_pred_binary_filtered, m_actual_positive}))
        else $error("result payload unknown");
endmodule

bind naive_bayes_text_classifier_top nbtc_props u_chk (
    .aclk, .aresetn, .s_ready, .m_valid, .m_ready, .m_pred_multinomial, .m_pred_binary,
    .m_pred_multinomial_filtered, .m_pred_binary_filtered, .m_actual_positive
);
